// ===== hw/rtl/qte_pkg.sv =====
// shared constants, types and helpers for the quaternion to euler angle core
// no dependencies; imported by every qte module
`default_nettype none

package qte_pkg;

  // cordic iteration count, limited by the step angle table
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  // operand widths
  localparam int OPW = 35;        // atan2 operands, scale 2^28
  localparam int SW = 30;         // clipped asin argument
  localparam int SQW = 58;        // square root radicand and remainder
  localparam int ROOT_BITS = 29;  // square root result
  localparam int CW = 37;         // cordic x and y
  localparam int ZW = 34;         // cordic angle, radians scaled by 2^30

  localparam logic signed [OPW-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;
  localparam logic signed [15:0] PITCH_MAX = 16'sd12868;

  // atan(2^-i) scaled by 2^30, truncated
  localparam logic [31:0] STEP_ANGLE [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // operands handed from the front end to the later stages
  typedef struct packed {
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [SW-1:0]  s;
    logic                  clip;
  } front_t;

  // round half up to q3.13 and clamp to +-lim
  function automatic logic signed [15:0] to_q13(input logic signed [ZW:0] a,
                                                input logic signed [15:0] lim);
    logic signed [ZW:0] r;
    logic signed [ZW:0] lim_ext;
    lim_ext = (ZW+1)'(lim);
    r = (a + $signed((ZW+1)'(65536))) >>> 17;
    if (r > lim_ext) begin
      r = lim_ext;
    end
    if (r < -lim_ext) begin
      r = -lim_ext;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qte_front.sv =====
// front end: input register, component products, atan2 operands and clipped asin argument
// depends on qte_pkg
`default_nettype none

module qte_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic signed [15:0]  q_w,
  input  wire logic signed [15:0]  q_x,
  input  wire logic signed [15:0]  q_y,
  input  wire logic signed [15:0]  q_z,
  output logic                     valid,
  output qte_pkg::front_t          data
);
  import qte_pkg::*;

  logic v1, v2;
  logic signed [15:0] w, x, y, z;
  logic signed [31:0] p_xx, p_yy, p_zz, p_yz, p_wx, p_xy, p_wz, p_xz, p_wy;
  logic signed [OPW-1:0] s_raw;
  front_t data_next;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      valid <= v2;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (en) begin
      w <= q_w;
      x <= q_x;
      y <= q_y;
      z <= q_z;
    end
  end

  // products, q4.28
  always_ff @(posedge clk) begin
    if (en) begin
      p_xx <= x * x;
      p_yy <= y * y;
      p_zz <= z * z;
      p_yz <= y * z;
      p_wx <= w * x;
      p_xy <= x * y;
      p_wz <= w * z;
      p_xz <= x * z;
      p_wy <= w * y;
    end
  end

  // operand sums and asin argument saturation
  always_comb begin
    data_next.roll_y = (OPW'(p_yz) + OPW'(p_wx)) <<< 1;
    data_next.roll_x = ONE_Q28 - ((OPW'(p_xx) + OPW'(p_yy)) <<< 1);
    data_next.yaw_y  = (OPW'(p_xy) + OPW'(p_wz)) <<< 1;
    data_next.yaw_x  = ONE_Q28 - ((OPW'(p_yy) + OPW'(p_zz)) <<< 1);
    s_raw = (OPW'(p_xz) - OPW'(p_wy)) <<< 1;
    data_next.clip = 1'b0;
    data_next.s = s_raw[SW-1:0];
    if (s_raw > ONE_Q28) begin
      data_next.s = ONE_Q28[SW-1:0];
      data_next.clip = 1'b1;
    end else if (s_raw < -ONE_Q28) begin
      data_next.s = -(ONE_Q28[SW-1:0]);
      data_next.clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qte_sqrt.sv =====
// pipelined square root of 1 - s^2, one result bit per stage
// depends on qte_pkg; carries the front end operands alongside
`default_nettype none

module qte_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire qte_pkg::front_t            side_in,
  output logic                            valid,
  output qte_pkg::front_t                 side,
  output logic [qte_pkg::ROOT_BITS-1:0]   root
);
  import qte_pkg::*;

  logic [SQW-1:0] sv [0:ROOT_BITS];
  logic [SQW-1:0] sr [0:ROOT_BITS];
  front_t         sd [0:ROOT_BITS];
  logic           vv [0:ROOT_BITS];
  logic signed [2*SW-1:0] sq;
  logic [2*SW-1:0] rad;

  // radicand 2^56 - s^2
  always_comb begin
    sq = side_in.s * side_in.s;
    rad = (60'd1 << 56) - $unsigned(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= rad[SQW-1:0];
      sr[0] <= '0;
      sd[0] <= side_in;
    end
  end

  // digit stages, trial bit 4^(ROOT_BITS-k)
  for (genvar k = 1; k <= ROOT_BITS; k++) begin : g_digit
    localparam logic [SQW-1:0] B = SQW'(1) << (2 * (ROOT_BITS - k));
    logic [SQW-1:0] trial;
    assign trial = sr[k-1] + B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= vv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= sd[k-1];
        if (sv[k-1] >= trial) begin
          sv[k] <= sv[k-1] - trial;
          sr[k] <= (sr[k-1] >> 1) + B;
        end else begin
          sv[k] <= sv[k-1];
          sr[k] <= sr[k-1] >> 1;
        end
      end
    end
  end

  assign valid = vv[ROOT_BITS];
  assign side = sd[ROOT_BITS];
  assign root = sr[ROOT_BITS][ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/qte_cordic.sv =====
// three-lane unrolled vectoring cordic for roll, pitch and yaw atan2
// depends on qte_pkg
`default_nettype none

module qte_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        valid_in,
  input  wire qte_pkg::front_t             side,
  input  wire logic [qte_pkg::ROOT_BITS-1:0] root,
  output logic                             valid,
  output logic                             clip,
  output logic signed [qte_pkg::ZW-1:0]    roll_a,
  output logic signed [qte_pkg::ZW-1:0]    pitch_a,
  output logic signed [qte_pkg::ZW-1:0]    yaw_a
);
  import qte_pkg::*;

  logic signed [CW-1:0] cx [0:2][0:CORDIC_N];
  logic signed [CW-1:0] cy [0:2][0:CORDIC_N];
  logic signed [ZW-1:0] cz [0:2][0:CORDIC_N];
  logic                 c0 [0:2][0:CORDIC_N];
  logic                 cv [0:CORDIC_N];
  logic                 cc [0:CORDIC_N];
  logic signed [CW-1:0] iy [0:2];
  logic signed [CW-1:0] ix [0:2];

  // lane operands
  always_comb begin
    iy[0] = CW'(side.roll_y);
    ix[0] = CW'(side.roll_x);
    iy[1] = CW'(side.s);
    ix[1] = CW'($signed({1'b0, root}));
    iy[2] = CW'(side.yaw_y);
    ix[2] = CW'(side.yaw_x);
  end

  // control bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc[0] <= side.clip;
    end
  end

  for (genvar i = 1; i <= CORDIC_N; i++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i] <= 1'b0;
      end else if (en) begin
        cv[i] <= cv[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cc[i] <= cc[i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // quadrant fold for a negative x operand
    always_ff @(posedge clk) begin
      if (en) begin
        c0[l][0] <= (ix[l] == '0) && (iy[l] == '0);
        if (ix[l] < 0) begin
          if (iy[l] >= 0) begin
            cx[l][0] <= iy[l];
            cy[l][0] <= -ix[l];
            cz[l][0] <= HALF_PI;
          end else begin
            cx[l][0] <= -iy[l];
            cy[l][0] <= ix[l];
            cz[l][0] <= -HALF_PI;
          end
        end else begin
          cx[l][0] <= ix[l];
          cy[l][0] <= iy[l];
          cz[l][0] <= '0;
        end
      end
    end

    // micro-rotations
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
      localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-32){1'b0}}, STEP_ANGLE[i]});
      logic signed [CW-1:0] dx, dy;
      assign dx = cy[l][i] >>> i;
      assign dy = cx[l][i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          c0[l][i+1] <= c0[l][i];
          if (cy[l][i] >= 0) begin
            cx[l][i+1] <= cx[l][i] + dx;
            cy[l][i+1] <= cy[l][i] - dy;
            cz[l][i+1] <= cz[l][i] + ANG;
          end else begin
            cx[l][i+1] <= cx[l][i] - dx;
            cy[l][i+1] <= cy[l][i] + dy;
            cz[l][i+1] <= cz[l][i] - ANG;
          end
        end
      end
    end
  end

  // zero vector gives a zero angle
  assign valid = cv[CORDIC_N];
  assign clip = cc[CORDIC_N];
  assign roll_a = c0[0][CORDIC_N] ? '0 : cz[0][CORDIC_N];
  assign pitch_a = c0[1][CORDIC_N] ? '0 : cz[1][CORDIC_N];
  assign yaw_a = c0[2][CORDIC_N] ? '0 : cz[2][CORDIC_N];

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_angles_core.sv =====
// quaternion to euler angles (zyx, ned to body) conversion core, top level
// depends on qte_pkg, qte_front, qte_sqrt, qte_cordic
//
// input channel: in_valid / in_stall with q_w, q_x, q_y, q_z in signed q2.14.
// output channel: out_valid / out_stall with roll, yaw (16 bit, signed q3.13)
// and pitch (15 bit, signed q2.13) in radians plus pitch_clipped, set when the asin
// argument left the unit range and was saturated.
// a beat moves on either channel at a clock edge with valid high, stall low.
// the pipeline is made of three front end stages, the squaring stage, one square
// root stage per result bit, the quadrant fold, one stage per cordic step (16 by
// default) and the rounding output register.
// throughput is one beat per cycle unless out_stall holds the pipeline, which
// holds up to 51 beats.
// when a result waits under out_stall the whole pipeline holds and in_stall
// rises; otherwise in_stall is low and a new beat enters every cycle.
// a synchronous reset clears every valid bit; no result is lost or repeated
// across a stall.
`default_nettype none

module quaternion_to_euler_angles_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  q_w,
  input  wire logic signed [15:0]  q_x,
  input  wire logic signed [15:0]  q_y,
  input  wire logic signed [15:0]  q_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       roll,
  output logic signed [14:0]       pitch,
  output logic signed [15:0]       yaw,
  output logic                     pitch_clipped
);
  import qte_pkg::*;

  logic en;
  logic f_valid, s_valid, c_valid, c_clip;
  front_t f_data, s_side;
  logic [ROOT_BITS-1:0] s_root;
  logic signed [ZW-1:0] roll_a, pitch_a, yaw_a;
  logic signed [15:0] pitch_q;

  // pipeline advances unless a finished beat is held
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  qte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .q_w      (q_w),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_z      (q_z),
    .valid    (f_valid),
    .data     (f_data)
  );

  qte_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (f_valid),
    .side_in  (f_data),
    .valid    (s_valid),
    .side     (s_side),
    .root     (s_root)
  );

  qte_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (s_valid),
    .side     (s_side),
    .root     (s_root),
    .valid    (c_valid),
    .clip     (c_clip),
    .roll_a   (roll_a),
    .pitch_a  (pitch_a),
    .yaw_a    (yaw_a)
  );

  // pitch is the negated asin angle
  assign pitch_q = to_q13(-((ZW+1)'(pitch_a)), PITCH_MAX);

  // rounding and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll <= to_q13((ZW+1)'(roll_a), ANGLE_MAX);
      yaw <= to_q13((ZW+1)'(yaw_a), ANGLE_MAX);
      pitch <= pitch_q[14:0];
      pitch_clipped <= c_clip;
    end
  end

  // checks
  a_reset_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_roll_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll <= 16'sd25736 && roll >= -16'sd25736))
    else $error("roll out of range");

  a_yaw_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw <= 16'sd25736 && yaw >= -16'sd25736))
    else $error("yaw out of range");

  a_pitch_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch <= 15'sd12868 && pitch >= -15'sd12868))
    else $error("pitch out of range");

endmodule

`default_nettype wire
